### design/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the partition scatter-add node table.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

   localparam int ROWS     = 4096;
   localparam int MAX_FEAT = 64;

   localparam int ROW_W   = $clog2(ROWS);
   localparam int FEAT_W  = (MAX_FEAT > 1) ? $clog2(MAX_FEAT) : 1;
   localparam int FADDR_W = ROW_W + FEAT_W;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam int REQ_DW = 72;
   localparam int RSP_DW = 80;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_ACC  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_OUTSIDE = 3'd1;
   localparam logic [2:0] ST_BAD_EL  = 3'd2;
   localparam logic [2:0] ST_NEG_DEG = 3'd3;
   localparam logic [2:0] ST_ROW_RNG = 3'd4;

   localparam logic [1:0] REG_PART_BASE  = 2'd0;
   localparam logic [1:0] REG_PART_LIMIT = 2'd1;
   localparam logic [1:0] REG_FEAT_COUNT = 2'd2;

   typedef struct packed {
      logic [30:0] part_base;
      logic [30:0] part_limit;
      logic [6:0]  feat_count;
   } cfg_type;

   typedef struct packed {
      logic load_in;
      logic check_en;
      logic rd_en;
      logic exec_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic err;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### design/pst_csr.sv
// ----------------------------------------------------------------------------
// pst_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_csr
   import pst_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   logic [30:0] part_base_ff, part_base_in;
   logic [30:0] part_limit_ff, part_limit_in;
   logic [6:0]  feat_count_ff, feat_count_in;
   logic        wr;
   logic [1:0]  idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[3:2];

   always_comb begin
      part_base_in  = part_base_ff;
      part_limit_in = part_limit_ff;
      feat_count_in = feat_count_ff;
      if (wr) begin
         case (idx)
            REG_PART_BASE:  part_base_in  = csr_pwdata[30:0];
            REG_PART_LIMIT: part_limit_in = csr_pwdata[30:0];
            REG_FEAT_COUNT: feat_count_in = csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_base_ff  <= '0;
         part_limit_ff <= '0;
         feat_count_ff <= 7'd1;
      end else begin
         part_base_ff  <= part_base_in;
         part_limit_ff <= part_limit_in;
         feat_count_ff <= feat_count_in;
      end
   end

   always_comb begin
      case (idx)
         REG_PART_BASE:  csr_prdata = {1'b0, part_base_ff};
         REG_PART_LIMIT: csr_prdata = {1'b0, part_limit_ff};
         REG_FEAT_COUNT: csr_prdata = {25'd0, feat_count_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.part_base  = part_base_ff;
   assign cfg.part_limit = part_limit_ff;
   assign cfg.feat_count = feat_count_ff;

endmodule

`default_nettype wire

### design/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer: accept, check, store read, execute and write back.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ctrl
   import pst_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  dp_status_type      status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_READ  = 4'b0100,
      S_EXEC  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check_en = 1'b1;
            state_in     = S_READ;
         end
         S_READ: begin
            cmd.rd_en = ~status.err;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            if (status.out_free) begin
               cmd.exec_en = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### design/pst_datapath.sv
// ----------------------------------------------------------------------------
// pst_datapath
// Item registers, range checks, degree and feature stores, saturating adder,
// record counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_datapath
   import pst_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  wire logic [1:0]        req_tuser,
   input  wire logic [REQ_DW-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [RSP_DW-1:0] rsp_tdata
);

   localparam int DEG_DEPTH  = ROWS;
   localparam int FEAT_DEPTH = ROWS * (2 ** FEAT_W);

   logic [31:0] deg_mem  [DEG_DEPTH];
   logic [31:0] feat_mem [FEAT_DEPTH];

   // item registers
   logic [1:0]  op_ff, op_in;
   logic [30:0] id_ff, id_in;
   logic [6:0]  elem_ff, elem_in;
   logic [31:0] val_ff, val_in;

   // check results
   logic [2:0]        st_ff, st_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [11:0]       lrow_ff, lrow_in;
   logic [FEAT_W-1:0] fidx_ff, fidx_in;

   logic [31:0] deg_rd_ff, feat_rd_ff;

   logic [31:0] cnt_ff, cnt_in;

   logic        vld_ff, vld_in;
   logic [2:0]  o_st_ff, o_st_in;
   logic [11:0] o_row_ff, o_row_in;
   logic [31:0] o_data_ff, o_data_in;
   logic        o_sat_ff, o_sat_in;
   logic [31:0] o_cnt_ff, o_cnt_in;

   logic [10:0] fcnt;
   logic        bad_elem, is_write, neg_deg, outside;
   logic [30:0] row_full;
   logic        elem_zero;
   logic [31:0] cur;
   logic [32:0] sum;
   logic [31:0] acc_val;
   logic        acc_sat;
   logic        ok, do_write;

   always_comb begin
      op_in   = op_ff;
      id_in   = id_ff;
      elem_in = elem_ff;
      val_in  = val_ff;
      if (cmd.load_in) begin
         op_in   = req_tuser;
         id_in   = req_tdata[30:0];
         elem_in = req_tdata[37:31];
         val_in  = req_tdata[69:38];
      end
   end

   // checks in priority order: element, degree sign, partition (accumulate only), row range
   always_comb begin
      fcnt     = ({4'd0, cfg.feat_count} > 11'(MAX_FEAT)) ? 11'(MAX_FEAT)
                                                          : {4'd0, cfg.feat_count};
      bad_elem = {4'd0, elem_ff} > fcnt;
      is_write = (op_ff == CMD_LOAD) || (op_ff == CMD_ACC);
      neg_deg  = is_write && (elem_ff == 7'd0) && val_ff[31];
      outside  = (id_ff < cfg.part_base) || (id_ff >= cfg.part_limit);
      row_full = (op_ff == CMD_ACC) ? (id_ff - cfg.part_base) : id_ff;
      if (bad_elem)
         st_in = ST_BAD_EL;
      else if (neg_deg)
         st_in = ST_NEG_DEG;
      else if ((op_ff == CMD_ACC) && outside)
         st_in = ST_OUTSIDE;
      else if (row_full >= 31'(ROWS))
         st_in = ST_ROW_RNG;
      else
         st_in = ST_OK;
      row_in  = row_full[ROW_W-1:0];
      lrow_in = ((st_in == ST_OK) || (st_in == ST_ROW_RNG)) ? row_full[11:0] : 12'd0;
      fidx_in = FEAT_W'(elem_ff - 7'd1);
      if (!cmd.check_en) begin
         st_in   = st_ff;
         row_in  = row_ff;
         lrow_in = lrow_ff;
         fidx_in = fidx_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      id_ff   <= id_in;
      elem_ff <= elem_in;
      val_ff  <= val_in;
      st_ff   <= st_in;
      row_ff  <= row_in;
      lrow_ff <= lrow_in;
      fidx_ff <= fidx_in;
   end

   assign elem_zero = (elem_ff == 7'd0);
   assign ok        = (st_ff == ST_OK);

   // saturating Q16.16 add
   always_comb begin
      cur     = elem_zero ? deg_rd_ff : feat_rd_ff;
      sum     = {cur[31], cur} + {val_ff[31], val_ff};
      acc_sat = (sum[32] != sum[31]);
      if (sum[32:31] == 2'b01)
         acc_val = 32'h7FFF_FFFF;
      else if (sum[32:31] == 2'b10)
         acc_val = 32'h8000_0000;
      else
         acc_val = sum[31:0];
   end

   assign do_write = cmd.exec_en && ok && ((op_ff == CMD_LOAD) || (op_ff == CMD_ACC));

   always_comb begin
      o_data_in = '0;
      o_sat_in  = 1'b0;
      if (ok) begin
         case (op_ff)
            CMD_LOAD: o_data_in = val_ff;
            CMD_ACC: begin
               o_data_in = acc_val;
               o_sat_in  = acc_sat;
            end
            default:  o_data_in = cur;
         endcase
      end
      cnt_in = cnt_ff;
      if (cmd.exec_en && ok && (op_ff == CMD_ACC) && elem_zero)
         cnt_in = cnt_ff + 32'd1;
      o_st_in  = st_ff;
      o_row_in = lrow_ff;
      o_cnt_in = cnt_in;
      if (!cmd.exec_en) begin
         o_data_in = o_data_ff;
         o_sat_in  = o_sat_ff;
         o_st_in   = o_st_ff;
         o_row_in  = o_row_ff;
         o_cnt_in  = o_cnt_ff;
      end
      if (cmd.exec_en)
         vld_in = 1'b1;
      else if (rsp_tready)
         vld_in = 1'b0;
      else
         vld_in = vld_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         deg_rd_ff  <= deg_mem[row_ff];
         feat_rd_ff <= feat_mem[{row_ff, fidx_ff}];
      end
      if (do_write && elem_zero)
         deg_mem[row_ff] <= o_data_in;
      if (do_write && !elem_zero)
         feat_mem[{row_ff, fidx_ff}] <= o_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      o_st_ff   <= o_st_in;
      o_row_ff  <= o_row_in;
      o_data_ff <= o_data_in;
      o_sat_ff  <= o_sat_in;
      o_cnt_ff  <= o_cnt_in;
   end

   assign status.err      = ~ok;
   assign status.out_free = ~vld_ff | rsp_tready;

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {o_cnt_ff, o_sat_ff, o_data_ff, o_row_ff, o_st_ff};

endmodule

`default_nettype wire

### design/partition_scatter_add_table.sv
// ----------------------------------------------------------------------------
// partition_scatter_add_table
// Flow: after an item is accepted the sequencer steps through check, store
//   read and execute; execute waits while an earlier result is not taken.
// Items: a new item is taken only in the idle state, after the sequencer's
//   read-modify-write pass over the single-port degree and feature stores.
// Reset: clears the sequencer, result valid and record counter; registers go
//   to part_base 0, part_limit 0, feat_count 1. Stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_scatter_add_table
   import pst_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // node_id[30:0], element[37:31], value[69:38], zero pad[71:70]
   input  wire logic [REQ_DW-1:0] req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // status[2:0], local_row[14:3], data[46:15], saturated[47], records_done[79:48]
   output logic      [RSP_DW-1:0] rsp_tdata,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   pst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pst_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

### design/pst_checker.sv
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks of the scatter-add node table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_checker
   import pst_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [RSP_DW-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous item in progress");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_ROW_RNG)
      else $error("undefined status code");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != ST_OK) |-> (rsp_tdata[46:15] == 32'd0)
         && !rsp_tdata[47])
      else $error("error result carries data or saturation");

endmodule

bind partition_scatter_add_table pst_checker u_pst_checker (.*);

`default_nettype wire
